### src/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

    localparam int VTX_W = 16;
    localparam int DEG_W = 16;
    localparam logic [DEG_W-1:0] DEGREE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] tgt;
        logic             self_loop;
    } edge_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_T,
        ST_DEC,
        ST_RD2,
        ST_EXEC,
        ST_OPEN_T,
        ST_MERGE_K,
        ST_SCAN,
        ST_OUT
    } back_state_t;

    function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
        deg_inc = (d < DEGREE_MAX) ? d + 1'b1 : d;
    endfunction

endpackage

### src/scc_ram.sv
`timescale 1ns / 1ps

module scc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] ram_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/scc_front.sv
`timescale 1ns / 1ps

module scc_front #(
    parameter int VERTICES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [9:0]           source_vertex,
    input  logic [9:0]           target_vertex,
    output logic                 q_valid,
    output scc_pkg::edge_t       q_item,
    input  logic                 q_ready
);

    function automatic int top_shift();
        int k;
        k = 0;
        while ((VERTICES << (k + 1)) <= 1023)
        begin
            k = k + 1;
        end
        return k;
    endfunction

    localparam bit NEED_MOD = (VERTICES < 1024);
    localparam int K0 = NEED_MOD ? top_shift() : 0;

    logic       busy_reg, busy_next;
    logic       valid_reg, valid_next;
    logic [9:0] rs_reg, rs_next;
    logic [9:0] rt_reg, rt_next;
    logic [3:0] step_reg, step_next;
    logic       accept;

    assign full   = busy_reg || (valid_reg && !q_ready);
    assign accept = push && !full;

    always_comb
    begin
        logic [31:0] sub_w;
        sub_w      = 32'(VERTICES) << step_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        rs_next    = rs_reg;
        rt_next    = rt_reg;
        step_next  = step_reg;
        if (valid_reg && q_ready)
        begin
            valid_next = 1'b0;
        end
        if (busy_reg)
        begin
            if (32'(rs_reg) >= sub_w)
            begin
                rs_next = rs_reg - 10'(sub_w);
            end
            if (32'(rt_reg) >= sub_w)
            begin
                rt_next = rt_reg - 10'(sub_w);
            end
            if (step_reg == 4'd0)
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 4'd1;
            end
        end
        if (accept)
        begin
            rs_next   = source_vertex;
            rt_next   = target_vertex;
            step_next = 4'(K0);
            if (NEED_MOD)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            rs_reg    <= '0;
            rt_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            rs_reg    <= rs_next;
            rt_reg    <= rt_next;
            step_reg  <= step_next;
        end
    end

    assign q_valid          = valid_reg;
    assign q_item.src       = scc_pkg::VTX_W'(rs_reg);
    assign q_item.tgt       = scc_pkg::VTX_W'(rt_reg);
    assign q_item.self_loop = (rs_reg == rt_reg);

endmodule

### src/scc_fifo.sv
`timescale 1ns / 1ps

module scc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  scc_pkg::edge_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    output scc_pkg::edge_t out_item,
    input  logic           out_pop
);

    scc_pkg::edge_t entry_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     count_reg;
    logic           do_wr, do_rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

### src/scc_back.sv
`timescale 1ns / 1ps

module scc_back #(
    parameter int VERTICES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  scc_pkg::edge_t q_item,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [10:0]    component_id,
    output logic           merged,
    output logic [15:0]    source_degree,
    output logic [15:0]    target_degree,
    output logic [10:0]    cluster_count,
    output logic [10:0]    clustered_vertices,
    output logic [10:0]    largest_cluster
);

    localparam int VW  = $clog2(VERTICES);
    localparam int IW  = $clog2(VERTICES + 1);
    localparam int SPW = $clog2(VERTICES + 2);
    localparam int DW  = scc_pkg::DEG_W;

    scc_pkg::back_state_t state_reg, state_next;

    logic [VW-1:0]  s_reg, s_next, t_reg, t_next;
    logic           self_reg, self_next;
    logic [IW-1:0]  ms_reg, ms_next, mt_reg, mt_next;
    logic [DW-1:0]  ds_reg, ds_next, dsn_reg, dsn_next, dtn_reg, dtn_next;
    logic [IW-1:0]  cid_reg, cid_next, keep_reg, keep_next, gone_reg, gone_next;
    logic [IW-1:0]  moved_reg, moved_next;
    logic           mrg_reg, mrg_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [IW-1:0]  nid_reg, nid_next;
    logic [IW-1:0]  act_reg, act_next, vic_reg, vic_next, max_reg, max_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic [VW:0]    scan_reg, scan_next;
    logic           ov_reg, ov_next;
    logic [10:0]    o_cid_reg, o_cid_next;
    logic           o_mrg_reg, o_mrg_next;
    logic [15:0]    o_ds_reg, o_ds_next, o_dt_reg, o_dt_next;
    logic [10:0]    o_cnt_reg, o_cnt_next, o_vic_reg, o_vic_next, o_max_reg, o_max_next;

    logic          mem_we;
    logic [VW-1:0] mem_waddr, mem_raddr;
    logic [IW-1:0] mem_wdata, mem_rdata;
    logic          deg_we;
    logic [VW-1:0] deg_waddr, deg_raddr;
    logic [DW-1:0] deg_wdata, deg_rdata;
    logic          csz_we;
    logic [IW-1:0] csz_waddr, csz_raddr, csz_wdata, csz_rdata;
    logic          stk_we;
    logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    scc_ram #(.W(IW), .D(VERTICES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    scc_ram #(.W(DW), .D(VERTICES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    scc_ram #(.W(IW), .D(VERTICES + 1)) u_csz (
        .clk(clk), .we(csz_we), .waddr(csz_waddr), .wdata(csz_wdata),
        .raddr(csz_raddr), .rdata(csz_rdata)
    );

    scc_ram #(.W(IW), .D(VERTICES + 1)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_comb
    begin
        logic [IW-1:0]  cid_w, nsz_w, amt_w;
        logic [SPW-1:0] sp1_w;

        state_next = state_reg;
        s_next = s_reg;       t_next = t_reg;       self_next = self_reg;
        ms_next = ms_reg;     mt_next = mt_reg;     ds_next = ds_reg;
        dsn_next = dsn_reg;   dtn_next = dtn_reg;   cid_next = cid_reg;
        keep_next = keep_reg; gone_next = gone_reg; moved_next = moved_reg;
        mrg_next = mrg_reg;   sp_next = sp_reg;     nid_next = nid_reg;
        act_next = act_reg;   vic_next = vic_reg;   max_next = max_reg;
        clr_next = clr_reg;   scan_next = scan_reg;
        ov_next = ov_reg;
        o_cid_next = o_cid_reg; o_mrg_next = o_mrg_reg;
        o_ds_next = o_ds_reg;   o_dt_next = o_dt_reg;
        o_cnt_next = o_cnt_reg; o_vic_next = o_vic_reg; o_max_next = o_max_reg;

        q_pop = 1'b0;
        mem_we = 1'b0; mem_waddr = s_reg; mem_wdata = '0; mem_raddr = s_reg;
        deg_we = 1'b0; deg_waddr = s_reg; deg_wdata = '0; deg_raddr = s_reg;
        csz_we = 1'b0; csz_waddr = '0;    csz_wdata = '0; csz_raddr = gone_reg;
        stk_we = 1'b0; stk_waddr = '0;    stk_wdata = '0;
        stk_raddr = IW'(sp_reg - SPW'(1));

        cid_w = '0;
        nsz_w = '0;
        amt_w = self_reg ? IW'(1) : IW'(2);
        sp1_w = (sp_reg == '0) ? '0 : sp_reg - SPW'(1);

        if (ov_reg && pop)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            scc_pkg::ST_CLEAR:
            begin
                mem_we    = (clr_reg < IW'(VERTICES));
                mem_waddr = VW'(clr_reg);
                deg_we    = (clr_reg < IW'(VERTICES));
                deg_waddr = VW'(clr_reg);
                csz_we    = 1'b1;
                csz_waddr = clr_reg;
                stk_we    = (clr_reg == '0);
                stk_wdata = IW'(1);
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(VERTICES))
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_IDLE:
            begin
                mem_raddr = VW'(q_item.src);
                deg_raddr = VW'(q_item.src);
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    s_next     = VW'(q_item.src);
                    t_next     = VW'(q_item.tgt);
                    self_next  = q_item.self_loop;
                    mrg_next   = 1'b0;
                    state_next = scc_pkg::ST_RD_T;
                end
            end
            scc_pkg::ST_RD_T:
            begin
                ms_next    = mem_rdata;
                ds_next    = deg_rdata;
                mem_raddr  = t_reg;
                deg_raddr  = t_reg;
                state_next = scc_pkg::ST_DEC;
            end
            scc_pkg::ST_DEC:
            begin
                mt_next = mem_rdata;
                if (self_reg)
                begin
                    dsn_next = scc_pkg::deg_inc(scc_pkg::deg_inc(ds_reg));
                    dtn_next = scc_pkg::deg_inc(scc_pkg::deg_inc(ds_reg));
                end
                else
                begin
                    dsn_next = scc_pkg::deg_inc(ds_reg);
                    dtn_next = scc_pkg::deg_inc(deg_rdata);
                end
                deg_we     = 1'b1;
                deg_waddr  = s_reg;
                deg_wdata  = dsn_next;
                state_next = scc_pkg::ST_RD2;
            end
            scc_pkg::ST_RD2:
            begin
                deg_we    = 1'b1;
                deg_waddr = t_reg;
                deg_wdata = dtn_reg;
                keep_next = (ms_reg < mt_reg) ? ms_reg : mt_reg;
                gone_next = (ms_reg < mt_reg) ? mt_reg : ms_reg;
                if (ms_reg != '0 && mt_reg == '0)
                begin
                    csz_raddr = ms_reg;
                end
                else if (ms_reg == '0 && mt_reg != '0)
                begin
                    csz_raddr = mt_reg;
                end
                else
                begin
                    csz_raddr = gone_next;
                end
                state_next = scc_pkg::ST_EXEC;
            end
            scc_pkg::ST_EXEC:
            begin
                if (ms_reg == '0 && mt_reg == '0)
                begin
                    cid_w = (sp_reg == '0) ? nid_reg : stk_rdata;
                    sp_next = sp1_w;
                    if (cid_w >= nid_reg)
                    begin
                        nid_next = cid_w + IW'(1);
                        if (sp1_w < SPW'(VERTICES + 1))
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = IW'(sp1_w);
                            stk_wdata = cid_w + IW'(1);
                            sp_next   = sp1_w + SPW'(1);
                        end
                    end
                    mem_we     = 1'b1;
                    mem_waddr  = s_reg;
                    mem_wdata  = cid_w;
                    csz_we     = 1'b1;
                    csz_waddr  = cid_w;
                    csz_wdata  = amt_w;
                    act_next   = act_reg + IW'(1);
                    vic_next   = vic_reg + amt_w;
                    max_next   = (amt_w > max_reg) ? amt_w : max_reg;
                    cid_next   = cid_w;
                    state_next = scc_pkg::ST_OPEN_T;
                end
                else if (ms_reg == '0 || mt_reg == '0)
                begin
                    cid_w      = (ms_reg != '0) ? ms_reg : mt_reg;
                    nsz_w      = csz_rdata + IW'(1);
                    mem_we     = 1'b1;
                    mem_waddr  = (ms_reg != '0) ? t_reg : s_reg;
                    mem_wdata  = cid_w;
                    csz_we     = 1'b1;
                    csz_waddr  = cid_w;
                    csz_wdata  = nsz_w;
                    vic_next   = vic_reg + IW'(1);
                    max_next   = (nsz_w > max_reg) ? nsz_w : max_reg;
                    cid_next   = cid_w;
                    state_next = scc_pkg::ST_OUT;
                end
                else if (ms_reg == mt_reg)
                begin
                    cid_next   = ms_reg;
                    state_next = scc_pkg::ST_OUT;
                end
                else
                begin
                    moved_next = csz_rdata;
                    csz_we     = 1'b1;
                    csz_waddr  = gone_reg;
                    csz_wdata  = '0;
                    csz_raddr  = keep_reg;
                    cid_next   = keep_reg;
                    mrg_next   = 1'b1;
                    state_next = scc_pkg::ST_MERGE_K;
                end
            end
            scc_pkg::ST_OPEN_T:
            begin
                mem_we     = 1'b1;
                mem_waddr  = t_reg;
                mem_wdata  = cid_reg;
                state_next = scc_pkg::ST_OUT;
            end
            scc_pkg::ST_MERGE_K:
            begin
                nsz_w     = csz_rdata + moved_reg;
                csz_we    = 1'b1;
                csz_waddr = keep_reg;
                csz_wdata = nsz_w;
                max_next  = (nsz_w > max_reg) ? nsz_w : max_reg;
                if (sp_reg < SPW'(VERTICES + 1))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = IW'(sp_reg);
                    stk_wdata = gone_reg;
                    sp_next   = sp_reg + SPW'(1);
                end
                if (act_reg != '0)
                begin
                    act_next = act_reg - IW'(1);
                end
                scan_next  = '0;
                state_next = scc_pkg::ST_SCAN;
            end
            scc_pkg::ST_SCAN:
            begin
                mem_raddr = VW'(scan_reg);
                if (scan_reg != '0 && mem_rdata == gone_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = VW'(scan_reg - (VW+1)'(1));
                    mem_wdata = keep_reg;
                end
                scan_next = scan_reg + (VW+1)'(1);
                if (scan_reg == (VW+1)'(VERTICES))
                begin
                    state_next = scc_pkg::ST_OUT;
                end
            end
            scc_pkg::ST_OUT:
            begin
                if (!ov_reg || pop)
                begin
                    ov_next    = 1'b1;
                    o_cid_next = 11'(cid_reg);
                    o_mrg_next = mrg_reg;
                    o_ds_next  = dsn_reg;
                    o_dt_next  = dtn_reg;
                    o_cnt_next = 11'(act_reg);
                    o_vic_next = 11'(vic_reg);
                    o_max_next = 11'(max_reg);
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_CLEAR;
            sp_reg    <= SPW'(1);
            nid_reg   <= IW'(1);
            act_reg   <= '0;
            vic_reg   <= '0;
            max_reg   <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            nid_reg   <= nid_next;
            act_reg   <= act_next;
            vic_reg   <= vic_next;
            max_reg   <= max_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;     t_reg     <= t_next;     self_reg  <= self_next;
        ms_reg    <= ms_next;    mt_reg    <= mt_next;    ds_reg    <= ds_next;
        dsn_reg   <= dsn_next;   dtn_reg   <= dtn_next;   cid_reg   <= cid_next;
        keep_reg  <= keep_next;  gone_reg  <= gone_next;  moved_reg <= moved_next;
        mrg_reg   <= mrg_next;   scan_reg  <= scan_next;
        o_cid_reg <= o_cid_next; o_mrg_reg <= o_mrg_next;
        o_ds_reg  <= o_ds_next;  o_dt_reg  <= o_dt_next;
        o_cnt_reg <= o_cnt_next; o_vic_reg <= o_vic_next; o_max_reg <= o_max_next;
    end

    assign empty              = !ov_reg;
    assign component_id       = o_cid_reg;
    assign merged             = o_mrg_reg;
    assign source_degree      = o_ds_reg;
    assign target_degree      = o_dt_reg;
    assign cluster_count      = o_cnt_reg;
    assign clustered_vertices = o_vic_reg;
    assign largest_cluster    = o_max_reg;

endmodule

### src/streaming_connected_components.sv
`timescale 1ns / 1ps

// Channel   Handshake     Beat
// edges     push / full   source_vertex, target_vertex
// results   pop / empty   component_id, merged, source_degree, target_degree,
//                         cluster_count, clustered_vertices, largest_cluster
//
// The back end works an edge with one memory port per store, read-modify-write
// of membership, degree, cluster size and id stack.
// A merge adds a membership relabel scan over all VERTICES entries.
// Below 1024 vertices the front end folds vertex numbers with one subtract
// step per cycle before the edge enters the 2-deep queue.
// After reset a clearing pass runs; edges queue but wait.
// A result waits in the output register while the next edge is worked on.

module streaming_connected_components #(
    parameter int VERTICES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [9:0]  source_vertex,
    input  logic [9:0]  target_vertex,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] component_id,
    output logic        merged,
    output logic [15:0] source_degree,
    output logic [15:0] target_degree,
    output logic [10:0] cluster_count,
    output logic [10:0] clustered_vertices,
    output logic [10:0] largest_cluster
);

    logic           f_valid, f_ready, b_valid, b_pop;
    scc_pkg::edge_t f_item, b_item;

    scc_front #(.VERTICES(VERTICES)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .source_vertex(source_vertex), .target_vertex(target_vertex),
        .q_valid(f_valid), .q_item(f_item), .q_ready(f_ready)
    );

    scc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_item(f_item), .in_ready(f_ready),
        .out_valid(b_valid), .out_item(b_item), .out_pop(b_pop)
    );

    scc_back #(.VERTICES(VERTICES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_item(b_item), .q_pop(b_pop),
        .pop(pop), .empty(empty),
        .component_id(component_id), .merged(merged),
        .source_degree(source_degree), .target_degree(target_degree),
        .cluster_count(cluster_count), .clustered_vertices(clustered_vertices),
        .largest_cluster(largest_cluster)
    );

    a_deg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (source_degree != 16'd0) && (target_degree != 16'd0))
        else $error("result with zero degree");

    a_count_le_vertices: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && VERTICES < 2048) |-> cluster_count <= clustered_vertices)
        else $error("more clusters than clustered vertices");

    a_largest_le_vertices: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && VERTICES < 2048) |-> largest_cluster <= clustered_vertices)
        else $error("largest cluster exceeds clustered vertices");

endmodule

### sim/streaming_connected_components_tb.sv
`timescale 1ns / 1ps

module streaming_connected_components_tb;

    localparam int NV        = 1024;
    localparam int DEG_SAT   = 65535;
    localparam int LIMIT     = 6000000;
    localparam int DRAIN_GAP = 2 * NV + 64;

    typedef struct {
        logic [10:0] cid;
        logic        mrg;
        logic [15:0] sdeg;
        logic [15:0] tdeg;
        logic [10:0] ccount;
        logic [10:0] cverts;
        logic [10:0] clargest;
    } edge_result_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [9:0]  source_vertex;
    logic [9:0]  target_vertex;
    logic        empty;
    logic        pop;
    logic [10:0] component_id;
    logic        merged;
    logic [15:0] source_degree;
    logic [15:0] target_degree;
    logic [10:0] cluster_count;
    logic [10:0] clustered_vertices;
    logic [10:0] largest_cluster;

    streaming_connected_components u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .source_vertex      (source_vertex),
        .target_vertex      (target_vertex),
        .empty              (empty),
        .pop                (pop),
        .component_id       (component_id),
        .merged             (merged),
        .source_degree      (source_degree),
        .target_degree      (target_degree),
        .cluster_count      (cluster_count),
        .clustered_vertices (clustered_vertices),
        .largest_cluster    (largest_cluster)
    );

    // graph state mirror
    logic [10:0] label_of [NV];
    logic [15:0] deg_of [NV];
    int          size_of [NV+1];
    logic [10:0] id_stack [NV+1];
    int          id_sp;
    int          fresh_id;
    int          live_clusters;
    int          member_total;
    int          biggest;

    edge_result_t result_q [$];
    int           errors;
    int           cycles;
    bit           idle_on;
    int           hold_off;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic void id_push(input int id);
        if (id_sp < NV + 1)
        begin
            id_stack[id_sp] = id[10:0];
            id_sp++;
        end
    endfunction

    function automatic int id_pop();
        if (id_sp == 0)
            return fresh_id;
        id_sp--;
        return id_stack[id_sp];
    endfunction

    function automatic void add_members(input int id, input int amount);
        size_of[id] += amount;
        member_total += amount;
        if (size_of[id] > biggest)
            biggest = size_of[id];
    endfunction

    function automatic edge_result_t apply_edge(input int s, input int t);
        edge_result_t r;
        int cs;
        int ct;
        int cid;
        int keep;
        int gone;
        int moved;
        r.mrg = 1'b0;
        if (deg_of[s] < DEG_SAT)
            deg_of[s]++;
        if (deg_of[t] < DEG_SAT)
            deg_of[t]++;
        cs = label_of[s];
        ct = label_of[t];
        if (cs == 0 && ct == 0)
        begin
            cid = id_pop();
            if (cid >= fresh_id)
            begin
                fresh_id = cid + 1;
                id_push(fresh_id);
            end
            label_of[s] = cid[10:0];
            label_of[t] = cid[10:0];
            live_clusters++;
            add_members(cid, (s == t) ? 1 : 2);
        end
        else if (ct == 0)
        begin
            cid = cs;
            label_of[t] = cid[10:0];
            add_members(cid, 1);
        end
        else if (cs == 0)
        begin
            cid = ct;
            label_of[s] = cid[10:0];
            add_members(cid, 1);
        end
        else if (cs == ct)
            cid = cs;
        else
        begin
            keep = (cs < ct) ? cs : ct;
            gone = (cs < ct) ? ct : cs;
            moved = size_of[gone];
            for (int v = 0; v < NV; v++)
                if (label_of[v] == gone)
                    label_of[v] = keep[10:0];
            size_of[gone] = 0;
            member_total -= moved;
            add_members(keep, moved);
            id_push(gone);
            if (live_clusters > 0)
                live_clusters--;
            cid = keep;
            r.mrg = 1'b1;
        end
        r.cid      = cid[10:0];
        r.sdeg     = deg_of[s];
        r.tdeg     = deg_of[t];
        r.ccount   = live_clusters[10:0];
        r.cverts   = member_total[10:0];
        r.clargest = biggest[10:0];
        return r;
    endfunction

    task automatic send_edge(input logic [9:0] s, input logic [9:0] t);
        push <= 1'b1;
        source_vertex <= s;
        target_vertex <= t;
        do
            @(posedge clk);
        while (full);
        result_q.insert(result_q.size(), apply_edge(s, t));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        wait (result_q.size() == 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        edge_result_t e;
        int stall;
        stall = 0;
        pop <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, component_id %0d",
                             $time, component_id);
                    errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    check_field("component_id", e.cid, component_id);
                    check_field("merged", e.mrg, merged);
                    check_field("source_degree", e.sdeg, source_degree);
                    check_field("target_degree", e.tdeg, target_degree);
                    check_field("cluster_count", e.ccount, cluster_count);
                    check_field("clustered_vertices", e.cverts, clustered_vertices);
                    check_field("largest_cluster", e.clargest, largest_cluster);
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 9);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic test_directed();
        send_edge(10'd0, 10'd0);
        send_edge(10'd1023, 10'd1023);
        send_edge(10'd0, 10'd1);
        send_edge(10'd5, 10'd6);
        send_edge(10'd1, 10'd5);
        send_edge(10'd5, 10'd1);
        send_edge(10'd6, 10'd0);
        send_edge(10'h2AA, 10'h155);
        send_edge(10'h155, 10'h2AA);
        send_edge(10'd1023, 10'd512);
        send_edge(10'd700, 10'd1023);
        send_edge(10'd512, 10'd6);
        send_edge(10'd20, 10'd21);
        send_edge(10'd22, 10'd23);
        send_edge(10'd21, 10'd22);
        send_edge(10'd30, 10'd31);
        send_edge(10'd2, 10'd3);
        send_edge(10'd2, 10'd2);
        send_edge(10'd3, 10'd20);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        for (int i = 0; i < 20; i++)
            send_edge($urandom_range(900, 1023), $urandom_range(900, 1023));
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int base;
        int span;
        logic [9:0] s;
        logic [9:0] t;
        base = 0;
        span = 8;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: span = 8;
                    1: span = 32;
                    2: span = 128;
                    default: span = 1024;
                endcase
                base = $urandom_range(0, 1023);
            end
            s = 10'(base + $urandom_range(0, span - 1));
            t = ($urandom_range(0, 9) == 0) ? s : 10'(base + $urandom_range(0, span - 1));
            send_edge(s, t);
        end
        wait_drained();
    endtask

    task automatic test_degree_growth();
        for (int i = 0; i < 40; i++)
            send_edge(10'd777, 10'd777);
        send_edge(10'd777, 10'd778);
        send_edge(10'd779, 10'd777);
        wait_drained();
    endtask

    initial
    begin
        push <= 1'b0;
        source_vertex <= '0;
        target_vertex <= '0;
        rst_n <= 1'b0;
        errors = 0;
        hold_off = 0;
        idle_on = 1'b1;
        for (int v = 0; v < NV; v++)
        begin
            label_of[v] = '0;
            deg_of[v] = '0;
        end
        for (int v = 0; v <= NV; v++)
        begin
            size_of[v] = 0;
            id_stack[v] = '0;
        end
        id_stack[0] = 11'd1;
        id_sp = 1;
        fresh_id = 1;
        live_clusters = 0;
        member_total = 0;
        biggest = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(1270);
        idle_on = 1'b0;
        test_random(200);
        test_degree_growth();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
src/scc_pkg.sv
src/scc_ram.sv
src/scc_front.sv
src/scc_fifo.sv
src/scc_back.sv
src/streaming_connected_components.sv
sim/streaming_connected_components_tb.sv
